@@ design/mse_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mse_pkg
// Shared types, constants and helpers of the breakpoint envelope generator.
// ----------------------------------------------------------------------------
package mse_pkg;

	localparam int MAX_STAGES = 8;
	localparam int STAGE_AW   = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
	localparam int CNT_W      = $clog2(MAX_STAGES + 1);
	localparam int SEG_W      = (CNT_W > 4) ? CNT_W : 4;

	localparam logic [16:0] ONE       = 17'd65536;
	localparam logic [14:0] LIN_CURVE = 15'd256;

	localparam logic [1:0] REG_START = 2'd0;
	localparam logic [1:0] REG_END   = 2'd1;
	localparam logic [1:0] REG_COUNT = 2'd2;

	typedef logic [16:0] val_t;

	typedef struct packed {
		val_t        x;
		val_t        y;
		logic [14:0] curve;
	} stage_t;

	typedef struct packed {
		val_t        shp;
		val_t        prior;
		logic        head;
		val_t        sx;
		val_t        sy;
		val_t        ex;
		val_t        ey;
		logic        curved;
		logic [14:0] z;
	} job_t;

	typedef logic [15:0][30:0] rtab_t;

	function automatic logic [63:0] isqrt64(input logic [63:0] a);
		logic [63:0] rem;
		logic [63:0] r;
		logic [63:0] b;
		rem = a;
		r   = '0;
		b   = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (rem >= r + b) begin
				rem = rem - (r + b);
				r   = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// 2^(-2^-(k+1)) in Q1.30, k = 0..15
	function automatic rtab_t build_rtab();
		rtab_t       tab;
		logic [63:0] r;
		r = isqrt64(64'd1 << 59);
		for (int k = 0; k < 16; k++) begin
			tab[k] = r[30:0];
			r      = isqrt64(r << 30);
		end
		return tab;
	endfunction

	localparam rtab_t R_TAB = build_rtab();

	function automatic val_t clip_val(input logic signed [39:0] v);
		val_t res;
		if (v < 40'sd0)
			res = '0;
		else if (v > 40'sd65536)
			res = ONE;
		else
			res = v[16:0];
		return res;
	endfunction

endpackage
`default_nettype wire

@@ design/mse_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mse_if
// Valid/ready channels: input items, result items, register writes.
// ----------------------------------------------------------------------------
interface mse_item_if;
	logic               valid;
	logic               ready;
	logic               op;
	logic               first;
	logic [16:0]        position;
	logic [16:0]        shape_in;
	logic [16:0]        prior;
	logic               head;
	logic [2:0]         stage_index;
	logic signed [18:0] stage_x;
	logic signed [18:0] stage_y;
	logic [14:0]        stage_curve;

	modport source (output valid, op, first, position, shape_in, prior, head,
		stage_index, stage_x, stage_y, stage_curve, input ready);
	modport sink (input valid, op, first, position, shape_in, prior, head,
		stage_index, stage_x, stage_y, stage_curve, output ready);
endinterface

interface mse_result_if;
	logic        valid;
	logic        ready;
	logic [16:0] level;

	modport source (output valid, level, input ready);
	modport sink (input valid, level, output ready);
endinterface

interface mse_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [16:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ design/mse_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mse_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mse_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  wire logic                                     clk,
	input  wire logic                                     we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                         wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

@@ design/mse_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mse_queue
// Two-entry job queue between the tracking front end and the math back end.
// ----------------------------------------------------------------------------
module mse_queue (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire mse_pkg::job_t in_job,
	output logic              out_valid,
	input  wire logic         out_ready,
	output mse_pkg::job_t     out_job
);

	mse_pkg::job_t ent_q [2];
	logic          wp_q;
	logic          rp_q;
	logic [1:0]    cnt_q;
	logic          push;
	logic          pop;

	assign in_ready  = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_job   = ent_q[rp_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push)
			ent_q[wp_q] <= in_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wp_q <= ~wp_q;
			if (pop)
				rp_q <= ~rp_q;
			if (push && !pop)
				cnt_q <= cnt_q + 2'd1;
			else if (pop && !push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

endmodule
`default_nettype wire

@@ design/mse_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mse_front
// Accepts items, writes the stage table, tracks the current segment and
// hands one job per sample to the back end.
// ----------------------------------------------------------------------------
module mse_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	mse_item_if.sink           item,
	input  wire logic [16:0]   start_level,
	input  wire logic [16:0]   end_level,
	input  wire logic [3:0]    stage_count,
	output logic               job_valid,
	input  wire logic          job_ready,
	output mse_pkg::job_t      job
);

	localparam logic [2:0] F_IDLE    = 3'd0;
	localparam logic [2:0] F_LD_RD   = 3'd1;
	localparam logic [2:0] F_LD_WR   = 3'd2;
	localparam logic [2:0] F_SEG_RD  = 3'd3;
	localparam logic [2:0] F_SEG_CHK = 3'd4;
	localparam logic [2:0] F_SEG_NXT = 3'd5;
	localparam logic [2:0] F_PUSH    = 3'd6;

	logic [2:0]               state_q;
	logic                     first_q;
	logic [16:0]              pos_q;
	logic [16:0]              shp_q;
	logic [16:0]              prior_q;
	logic                     head_q;
	logic [2:0]               idx_q;
	logic signed [18:0]       xin_q;
	logic signed [18:0]       yin_q;
	logic [14:0]              crv_q;
	logic                     lin_q;

	logic [mse_pkg::SEG_W-1:0] seg_q;
	logic [16:0]              sx_q;
	logic [16:0]              sy_q;
	logic [16:0]              ex_q;
	logic [16:0]              ey_q;
	logic                     curved_q;
	logic [14:0]              z_q;

	logic [mse_pkg::SEG_W-1:0] count;
	logic [mse_pkg::SEG_W-1:0] cnt_ext;
	logic [mse_pkg::SEG_W-1:0] cur;
	logic [mse_pkg::SEG_W-1:0] nxt;
	logic [mse_pkg::SEG_W-1:0] idx_m1;
	logic [mse_pkg::SEG_W-1:0] raddr_w;
	logic                     accept;

	logic                     we;
	mse_pkg::stage_t          wdata;
	mse_pkg::stage_t          rd;
	logic [mse_pkg::STAGE_AW-1:0] raddr;
	logic [mse_pkg::STAGE_AW-1:0] waddr;

	logic [16:0]              last_x;
	logic signed [19:0]       xc;
	logic [16:0]              st_x;
	logic [16:0]              st_y;
	logic [16:0]              en_x;
	logic [16:0]              en_y;
	logic                     adv;

	assign cnt_ext = mse_pkg::SEG_W'(stage_count);
	assign count   = (cnt_ext > mse_pkg::SEG_W'(mse_pkg::MAX_STAGES)) ?
		mse_pkg::SEG_W'(mse_pkg::MAX_STAGES) : cnt_ext;
	assign cur     = first_q ? '0 : seg_q;
	assign nxt     = cur + 1'b1;
	assign idx_m1  = mse_pkg::SEG_W'(idx_q) - 1'b1;
	assign accept  = item.valid && item.ready;

	assign item.ready = (state_q == F_IDLE);

	always_comb begin
		case (state_q)
			F_LD_RD:   raddr_w = idx_m1;
			F_SEG_CHK: raddr_w = nxt;
			default:   raddr_w = cur;
		endcase
	end
	assign raddr = raddr_w[mse_pkg::STAGE_AW-1:0];
	assign waddr = mse_pkg::STAGE_AW'(mse_pkg::SEG_W'(idx_q));

	// load clamping: raise to the previous x, then clip both to 0..1
	assign last_x = (idx_q == 3'd0) ? 17'd0 : rd.x;
	assign xc     = ($signed({xin_q[18], xin_q}) < $signed({3'b0, last_x})) ?
		$signed({3'b0, last_x}) : $signed({xin_q[18], xin_q});
	assign we          = (state_q == F_LD_WR);
	assign wdata.x     = mse_pkg::clip_val(40'(xc));
	assign wdata.y     = mse_pkg::clip_val(40'(yin_q));
	assign wdata.curve = crv_q;

	mse_ram #(
		.WIDTH ($bits(mse_pkg::stage_t)),
		.DEPTH (mse_pkg::MAX_STAGES)
	) u_table (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rd)
	);

	assign st_x = first_q ? 17'd0 : sx_q;
	assign st_y = first_q ? start_level : sy_q;
	assign en_x = first_q ? rd.x : ex_q;
	assign en_y = first_q ? rd.y : ey_q;
	assign adv  = (cur < count) && (pos_q >= rd.x);

	always_ff @(posedge clk) begin
		if (accept) begin
			first_q <= item.first;
			pos_q   <= item.position;
			shp_q   <= item.shape_in;
			prior_q <= item.prior;
			head_q  <= item.head;
			idx_q   <= item.stage_index;
			xin_q   <= item.stage_x;
			yin_q   <= item.stage_y;
			crv_q   <= item.stage_curve;
			lin_q   <= (count == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= F_IDLE;
			seg_q    <= '0;
			sx_q     <= '0;
			sy_q     <= '0;
			ex_q     <= '0;
			ey_q     <= '0;
			curved_q <= 1'b0;
			z_q      <= '0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (accept) begin
						if (item.op) begin
							if (int'(item.stage_index) < mse_pkg::MAX_STAGES)
								state_q <= F_LD_RD;
						end else if (count == '0) begin
							state_q <= F_PUSH;
						end else begin
							state_q <= F_SEG_RD;
						end
					end
				end
				F_LD_RD:  state_q <= F_LD_WR;
				F_LD_WR:  state_q <= F_IDLE;
				F_SEG_RD: state_q <= F_SEG_CHK;
				F_SEG_CHK: begin
					if (adv) begin
						sx_q  <= en_x;
						sy_q  <= en_y;
						seg_q <= nxt;
						if (nxt >= count) begin
							ex_q     <= mse_pkg::ONE;
							ey_q     <= end_level;
							curved_q <= 1'b0;
							state_q  <= F_PUSH;
						end else begin
							state_q <= F_SEG_NXT;
						end
					end else begin
						sx_q     <= st_x;
						sy_q     <= st_y;
						ex_q     <= en_x;
						ey_q     <= en_y;
						seg_q    <= cur;
						curved_q <= (cur < count) && (rd.curve != mse_pkg::LIN_CURVE);
						z_q      <= rd.curve;
						state_q  <= F_PUSH;
					end
				end
				F_SEG_NXT: begin
					ex_q     <= rd.x;
					ey_q     <= rd.y;
					curved_q <= (rd.curve != mse_pkg::LIN_CURVE);
					z_q      <= rd.curve;
					state_q  <= F_PUSH;
				end
				F_PUSH: begin
					if (job_ready)
						state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	assign job_valid  = (state_q == F_PUSH);
	assign job.shp    = shp_q;
	assign job.prior  = prior_q;
	assign job.head   = head_q;
	assign job.sx     = lin_q ? 17'd0 : sx_q;
	assign job.sy     = lin_q ? start_level : sy_q;
	assign job.ex     = lin_q ? mse_pkg::ONE : ex_q;
	assign job.ey     = lin_q ? end_level : ey_q;
	assign job.curved = !lin_q && curved_q;
	assign job.z      = z_q;

endmodule
`default_nettype wire

@@ design/mse_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mse_back
// Level arithmetic for one job: bit-serial divider, log2/exp2 power,
// scaling, clipping and multiply mode, into the output register.
// ----------------------------------------------------------------------------
module mse_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          job_valid,
	output logic               job_ready,
	input  wire mse_pkg::job_t job,
	mse_result_if.source       result
);

	localparam logic [4:0] B_IDLE   = 5'd0;
	localparam logic [4:0] B_PREP   = 5'd1;
	localparam logic [4:0] B_LMUL   = 5'd2;
	localparam logic [4:0] B_LSET   = 5'd3;
	localparam logic [4:0] B_DIV    = 5'd4;
	localparam logic [4:0] B_DFIN   = 5'd5;
	localparam logic [4:0] B_LFIN   = 5'd6;
	localparam logic [4:0] B_TSEL   = 5'd7;
	localparam logic [4:0] B_LOG    = 5'd8;
	localparam logic [4:0] B_P      = 5'd9;
	localparam logic [4:0] B_EXPSET = 5'd10;
	localparam logic [4:0] B_EXP    = 5'd11;
	localparam logic [4:0] B_SHF    = 5'd12;
	localparam logic [4:0] B_FMUL   = 5'd13;
	localparam logic [4:0] B_FSUM   = 5'd14;
	localparam logic [4:0] B_COMB   = 5'd15;
	localparam logic [4:0] B_MP     = 5'd16;
	localparam logic [4:0] B_OUT    = 5'd17;

	logic [4:0]          st_q;
	mse_pkg::job_t       job_q;
	logic [18:0]         dsor_q;
	logic [34:0]         num_q;
	logic [18:0]         rem_q;
	logic [34:0]         quo_q;
	logic [5:0]          cnt_q;
	logic                neg_q;
	logic signed [36:0]  prod_q;
	logic signed [37:0]  v_q;
	logic [31:0]         x_q;
	logic [15:0]         lg_q;
	logic [3:0]          m_q;
	logic [27:0]         p_q;
	logic [30:0]         acc_q;
	logic [16:0]         pw_q;
	logic [16:0]         res_q;
	logic [16:0]         lvl_q;
	logic                ov_q;

	logic signed [17:0]  dx;
	logic signed [17:0]  dy;
	logic signed [17:0]  dshp;
	logic                fall;
	logic signed [35:0]  lp;
	logic signed [37:0]  n2;
	logic signed [37:0]  mag;
	logic [18:0]         remsh;
	logic                ge;
	logic [37:0]         qe;
	logic [37:0]         qinc;
	logic signed [37:0]  qf;
	logic [16:0]         traw;
	logic [16:0]         tt;
	logic [3:0]          msb;
	logic [63:0]         sq;
	logic [31:0]         xn;
	logic [20:0]         lq;
	logic [35:0]         pz;
	logic [3:0]          k;
	logic [61:0]         am;
	logic [4:0]          sh;
	logic [31:0]         rsum;
	logic [16:0]         f;
	logic signed [35:0]  fm;
	logic signed [36:0]  rnd;
	logic [16:0]         vc;
	logic [33:0]         mp;
	logic                load;

	assign dx    = $signed({1'b0, job_q.ex}) - $signed({1'b0, job_q.sx});
	assign dy    = $signed({1'b0, job_q.ey}) - $signed({1'b0, job_q.sy});
	assign dshp  = $signed({1'b0, job_q.shp}) - $signed({1'b0, job_q.sx});
	assign fall  = (job_q.ey < job_q.sy);

	assign lp    = dshp * dy;
	assign n2    = $signed({prod_q, 1'b0}) + 38'(dx);
	assign mag   = n2[37] ? -n2 : n2;
	assign remsh = {rem_q[17:0], num_q[34]};
	assign ge    = (remsh >= dsor_q);
	assign qe    = {3'b0, quo_q};
	assign qinc  = qe + 38'(rem_q != 19'd0);
	assign qf    = neg_q ? -$signed(qinc) : $signed(qe);

	assign traw  = (quo_q > 35'd65536) ? mse_pkg::ONE : quo_q[16:0];
	assign tt    = fall ? (mse_pkg::ONE - traw) : traw;

	always_comb begin
		msb = '0;
		for (int i = 0; i < 16; i++) begin
			if (tt[i])
				msb = 4'(i);
		end
	end

	assign sq   = x_q * x_q;
	assign xn   = sq[61:30];
	assign lq   = 21'd1048576 - {1'b0, m_q, lg_q};
	assign pz   = lq * job_q.z + 36'd128;
	assign k    = cnt_q[3:0];
	assign am   = acc_q * mse_pkg::R_TAB[k];
	assign sh   = 5'd14 + p_q[20:16];
	assign rsum = {1'b0, acc_q} + (32'd1 << (sh - 5'd1));
	assign f    = fall ? (mse_pkg::ONE - pw_q) : pw_q;
	assign fm   = $signed({1'b0, f}) * dy;
	assign rnd  = prod_q + 37'sd32768;
	assign vc   = mse_pkg::clip_val(40'(v_q));
	assign mp   = vc * job_q.prior;

	assign job_ready    = (st_q == B_IDLE);
	assign load         = (st_q == B_OUT) && (!ov_q || result.ready);
	assign result.valid = ov_q;
	assign result.level = lvl_q;

	always_ff @(posedge clk) begin
		if (job_valid && job_ready)
			job_q <= job;
		if (load)
			lvl_q <= res_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= B_IDLE;
			ov_q   <= 1'b0;
			dsor_q <= '0;
			num_q  <= '0;
			rem_q  <= '0;
			quo_q  <= '0;
			cnt_q  <= '0;
			neg_q  <= 1'b0;
			prod_q <= '0;
			v_q    <= '0;
			x_q    <= '0;
			lg_q   <= '0;
			m_q    <= '0;
			p_q    <= '0;
			acc_q  <= '0;
			pw_q   <= '0;
			res_q  <= '0;
		end else begin
			if (load)
				ov_q <= 1'b1;
			else if (result.ready)
				ov_q <= 1'b0;

			case (st_q)
				B_IDLE: begin
					if (job_valid)
						st_q <= B_PREP;
				end
				B_PREP: begin
					if (job_q.ex <= job_q.sx) begin
						v_q  <= 38'({1'b0, job_q.sy});
						st_q <= B_COMB;
					end else if (job_q.curved) begin
						if (job_q.shp <= job_q.sx) begin
							quo_q <= '0;
							st_q  <= B_TSEL;
						end else begin
							num_q  <= {2'b0, dshp[16:0], 16'b0};
							dsor_q <= {1'b0, dx};
							rem_q  <= '0;
							cnt_q  <= 6'd34;
							st_q   <= B_DIV;
						end
					end else begin
						st_q <= B_LMUL;
					end
				end
				B_LMUL: begin
					prod_q <= 37'(lp);
					st_q   <= B_LSET;
				end
				B_LSET: begin
					neg_q  <= n2[37];
					num_q  <= mag[34:0];
					dsor_q <= {dx, 1'b0};
					rem_q  <= '0;
					cnt_q  <= 6'd34;
					st_q   <= B_DIV;
				end
				B_DIV: begin
					rem_q <= ge ? (remsh - dsor_q) : remsh;
					num_q <= {num_q[33:0], 1'b0};
					quo_q <= {quo_q[33:0], ge};
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == 6'd0)
						st_q <= B_DFIN;
				end
				B_DFIN: st_q <= job_q.curved ? B_TSEL : B_LFIN;
				B_LFIN: begin
					v_q  <= $signed({21'b0, job_q.sy}) + qf;
					st_q <= B_COMB;
				end
				B_TSEL: begin
					if (job_q.z == 15'd0 || tt >= mse_pkg::ONE) begin
						pw_q <= mse_pkg::ONE;
						st_q <= B_FMUL;
					end else if (tt == 17'd0) begin
						pw_q <= '0;
						st_q <= B_FMUL;
					end else begin
						m_q   <= msb;
						x_q   <= {16'b0, tt[15:0]} << (5'd30 - {1'b0, msb});
						lg_q  <= '0;
						cnt_q <= 6'd15;
						st_q  <= B_LOG;
					end
				end
				B_LOG: begin
					if (xn[31]) begin
						x_q  <= {1'b0, xn[31:1]};
						lg_q <= {lg_q[14:0], 1'b1};
					end else begin
						x_q  <= xn;
						lg_q <= {lg_q[14:0], 1'b0};
					end
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == 6'd0)
						st_q <= B_P;
				end
				B_P: begin
					p_q  <= pz[35:8];
					st_q <= B_EXPSET;
				end
				B_EXPSET: begin
					if (p_q[27:16] >= 12'd17) begin
						pw_q <= '0;
						st_q <= B_FMUL;
					end else begin
						acc_q <= 31'd1 << 30;
						cnt_q <= '0;
						st_q  <= B_EXP;
					end
				end
				B_EXP: begin
					if (p_q[4'd15 - k])
						acc_q <= am[60:30];
					cnt_q <= cnt_q + 6'd1;
					if (k == 4'd15)
						st_q <= B_SHF;
				end
				B_SHF: begin
					pw_q <= 17'(rsum >> sh);
					st_q <= B_FMUL;
				end
				B_FMUL: begin
					prod_q <= 37'(fm);
					st_q   <= B_FSUM;
				end
				B_FSUM: begin
					v_q  <= $signed({21'b0, job_q.sy}) + 38'(rnd >>> 16);
					st_q <= B_COMB;
				end
				B_COMB: begin
					if (job_q.head) begin
						res_q <= vc;
						st_q  <= B_OUT;
					end else begin
						prod_q <= 37'(mp);
						st_q   <= B_MP;
					end
				end
				B_MP: begin
					res_q <= mse_pkg::clip_val(40'(rnd >>> 16));
					st_q  <= B_OUT;
				end
				B_OUT: begin
					if (load)
						st_q <= B_IDLE;
				end
				default: st_q <= B_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

@@ design/multi_stage_curved_envelope.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// multi_stage_curved_envelope
// Piecewise breakpoint envelope generator, Q1.16 levels, Q7.8 curve exponent.
// ----------------------------------------------------------------------------
// A load item passes through the front end states F_LD_RD and F_LD_WR; a sample
// goes straight to F_PUSH with no stages in use, else through F_SEG_RD, F_SEG_CHK
// and possibly F_SEG_NXT (one table read per stage lookup), and then waits in a
// two-entry queue for the arithmetic back end, which sets the sample rate: a
// straight segment uses a 35-step bit-serial divider, a curved one at most the
// divider, 16 log2 squarings and 16 exp2 multiplies, a zero-width segment none
// of these, and multiply mode adds the B_MP state. Results leave through an
// output register, so the back end frees up while a result waits for transfer.
// Register writes are always ready and must be made while the block is idle.
module multi_stage_curved_envelope (
	input  wire logic    clk,
	input  wire logic    arst_n,
	mse_item_if.sink     item,
	mse_result_if.source result,
	mse_cfg_if.sink      cfg
);

	logic [16:0]   start_q;
	logic [16:0]   end_q;
	logic [3:0]    count_q;
	logic          fq_valid;
	logic          fq_ready;
	mse_pkg::job_t fq_job;
	logic          qb_valid;
	logic          qb_ready;
	mse_pkg::job_t qb_job;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			end_q   <= mse_pkg::ONE;
			count_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				mse_pkg::REG_START: start_q <= cfg.data;
				mse_pkg::REG_END:   end_q   <= cfg.data;
				mse_pkg::REG_COUNT: count_q <= cfg.data[3:0];
				default: ;
			endcase
		end
	end

	mse_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item),
		.start_level (start_q),
		.end_level   (end_q),
		.stage_count (count_q),
		.job_valid   (fq_valid),
		.job_ready   (fq_ready),
		.job         (fq_job)
	);

	mse_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fq_valid),
		.in_ready  (fq_ready),
		.in_job    (fq_job),
		.out_valid (qb_valid),
		.out_ready (qb_ready),
		.out_job   (qb_job)
	);

	mse_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (qb_valid),
		.job_ready (qb_ready),
		.job       (qb_job),
		.result    (result)
	);

endmodule
`default_nettype wire
